>>> rtl/srcc_pkg.sv
// ----------------------------------------------------------------------------
// srcc_pkg: shared types and constants of the symmetric row convolution
// widths, register indexes, job and configuration records
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package srcc_pkg;

  // pixel and position widths
  localparam int PIX_W      = 16;
  localparam int POS_W      = 12;
  localparam int TAP_W      = 16;

  // kernel geometry
  localparam int MAX_HALF   = 7;
  localparam int HALF_W     = 3;
  localparam int N_TAPS     = MAX_HALF + 1;
  localparam int WIN_DEPTH  = 2 * MAX_HALF + 1;
  localparam int WIN_IDX_W  = 4;
  localparam int FILL_W     = 4;

  // results of one word at most, and the job counter width
  localparam int RES_MAX    = 8;
  localparam int JOB_CNT_W  = 4;

  // datapath widths: pre-add, product, partial sum, full sum
  localparam int SUM_W      = PIX_W + 1;
  localparam int PROD_W     = SUM_W + TAP_W;
  localparam int PART_W     = PROD_W + 2;
  localparam int ACC_W      = PROD_W + 3;
  localparam int RND_W      = ACC_W - TAP_W;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KERNEL_HALF = 2'd0,
    CFG_TAPS_LOW    = 2'd1,
    CFG_TAPS_HIGH   = 2'd2
  } cfg_idx_t;

  // live configuration, tap 0 is the centre weight
  typedef struct packed {
    logic [HALF_W-1:0]             half;
    logic [N_TAPS-1:0][TAP_W-1:0]  taps;
  } cfg_t;

  // one filter job: window snapshot, its fill, centre offset and tags
  typedef struct packed {
    logic [WIN_DEPTH-1:0][PIX_W-1:0] win;
    logic [FILL_W-1:0]               fill;
    logic [HALF_W-1:0]               m;
    logic [POS_W-1:0]                pos;
    logic                            last;
  } job_t;

endpackage

`default_nettype wire

>>> rtl/srcc_if.sv
// ----------------------------------------------------------------------------
// srcc_if: stream interfaces of the row convolution
// pixel words in, filtered words out, valid/ready handshake
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface srcc_in_if;
  logic                       valid;
  logic                       ready;
  logic [srcc_pkg::PIX_W-1:0] pixel;
  logic                       row_last;

  modport source (output valid, output pixel, output row_last, input ready);
  modport sink   (input valid, input pixel, input row_last, output ready);
endinterface

interface srcc_out_if;
  logic                       valid;
  logic                       ready;
  logic [srcc_pkg::PIX_W-1:0] blurred_pixel;
  logic [srcc_pkg::POS_W-1:0] position;
  logic                       last_of_row;

  modport source (output valid, output blurred_pixel, output position,
                  output last_of_row, input ready);
  modport sink   (input valid, input blurred_pixel, input position,
                  input last_of_row, output ready);
endinterface

`default_nettype wire

>>> rtl/symmetric_row_convolution_clamped_core.sv
// ----------------------------------------------------------------------------
// symmetric_row_convolution_clamped_core: 1-D symmetric row filter
// edge-replicating FIR over a pixel row, Q0.16 taps, rounded and saturated
//
//   channel  dir  handshake               words
//   in_chan  in   valid/ready             pixel, row_last
//   out_chan out  valid/ready             blurred_pixel, position, last_of_row
//   cfg_*    in   cfg_we, no back-press.  cfg_index, cfg_wdata
//
// one pixel word accepted per cycle unless a flush or stall holds ready low;
// its first result passes the job register, queue, three pipeline stages and
// output register
// the last word of a row holds in_chan.ready low until the single-job-per-cycle
// generator, while the queue has room, issues each extra flushed column (up to seven)
// synchronous active-low reset clears counters, valid bits and control registers
// a stall on out_chan backs up through the two-entry queue to in_chan
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module symmetric_row_convolution_clamped_core (
  input  logic                            clk,
  input  logic                            rst_n,
  srcc_in_if.sink                         in_chan,
  srcc_out_if.source                      out_chan,
  input  logic                            cfg_we,
  input  logic [srcc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [srcc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  // configuration registers
  logic [srcc_pkg::HALF_W-1:0]     half_r, half_nxt;
  logic [srcc_pkg::CFG_DATA_W-1:0] taps_lo_r, taps_lo_nxt;
  logic [srcc_pkg::CFG_DATA_W-1:0] taps_hi_r, taps_hi_nxt;
  srcc_pkg::cfg_t                  cfg;

  always_comb begin
    half_nxt    = half_r;
    taps_lo_nxt = taps_lo_r;
    taps_hi_nxt = taps_hi_r;
    if (cfg_we) begin
      case (srcc_pkg::cfg_idx_t'(cfg_index))
        srcc_pkg::CFG_KERNEL_HALF: half_nxt    = cfg_wdata[srcc_pkg::HALF_W-1:0];
        srcc_pkg::CFG_TAPS_LOW:    taps_lo_nxt = cfg_wdata;
        srcc_pkg::CFG_TAPS_HIGH:   taps_hi_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r    <= '0;
      taps_lo_r <= '0;
      taps_hi_r <= '0;
    end else begin
      half_r    <= half_nxt;
      taps_lo_r <= taps_lo_nxt;
      taps_hi_r <= taps_hi_nxt;
    end
  end

  assign cfg.half = half_r;
  assign cfg.taps = {taps_hi_r, taps_lo_r};

  // front to queue
  logic           f_valid, f_ready;
  srcc_pkg::job_t f_job;

  // queue to back
  logic           q_valid, q_ready;
  srcc_pkg::job_t q_job;

  srcc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .cfg       (cfg),
    .job_valid (f_valid),
    .job       (f_job),
    .job_ready (f_ready)
  );

  srcc_job_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_job   (f_job),
    .wr_ready (f_ready),
    .rd_valid (q_valid),
    .rd_job   (q_job),
    .rd_ready (q_ready)
  );

  srcc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .job_valid (q_valid),
    .job       (q_job),
    .job_ready (q_ready),
    .out_chan  (out_chan)
  );

endmodule

`default_nettype wire

>>> rtl/srcc_front.sv
// ----------------------------------------------------------------------------
// srcc_front: input side of the row convolution
// shifts pixels into the window, keeps the row counters and issues one
// filter job per column, several at the end of a row
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srcc_front (
  input  logic                 clk,
  input  logic                 rst_n,
  srcc_in_if.sink              in_chan,
  input  srcc_pkg::cfg_t       cfg,
  output logic                 job_valid,
  output srcc_pkg::job_t       job,
  input  logic                 job_ready
);

  // window and row state
  logic [srcc_pkg::WIN_DEPTH-1:0][srcc_pkg::PIX_W-1:0] win_r, win_nxt;
  logic [srcc_pkg::FILL_W-1:0]    fill_r, fill_nxt;
  logic [srcc_pkg::POS_W-1:0]     in_cnt_r, in_cnt_nxt;
  logic [srcc_pkg::POS_W-1:0]     out_cnt_r, out_cnt_nxt;
  logic                           end_r, end_nxt;

  // job generator
  logic [srcc_pkg::JOB_CNT_W-1:0] gen_cnt_r, gen_cnt_nxt;
  logic                           gen_norm_r, gen_norm_nxt;
  logic [srcc_pkg::POS_W-1:0]     gen_pos_r, gen_pos_nxt;

  // effective state at the next word: cleared once the row has ended
  logic [srcc_pkg::FILL_W-1:0]    fill_e, fill_n;
  logic [srcc_pkg::POS_W-1:0]     ic_e, oc_e, ic_n, oc1, pend;
  logic                           emitn;
  logic [srcc_pkg::JOB_CNT_W-1:0] cap, flush;
  logic                           accept, push;
  logic [srcc_pkg::JOB_CNT_W-1:0] cnt_m1;

  // handshakes
  assign push          = (gen_cnt_r != '0) && job_ready;
  assign in_chan.ready = (gen_cnt_r == '0)
                       || ((gen_cnt_r == srcc_pkg::JOB_CNT_W'(1)) && push);
  assign accept        = in_chan.valid && in_chan.ready;

  // job presented to the queue
  assign cnt_m1    = gen_cnt_r - srcc_pkg::JOB_CNT_W'(1);
  assign job_valid = (gen_cnt_r != '0);
  always_comb begin
    job.win  = win_r;
    job.fill = fill_r;
    job.m    = gen_norm_r ? cfg.half : cnt_m1[srcc_pkg::HALF_W-1:0];
    job.pos  = gen_pos_r;
    job.last = end_r && (gen_cnt_r == srcc_pkg::JOB_CNT_W'(1));
  end

  // column bookkeeping for an incoming word
  always_comb begin
    fill_e = end_r ? '0 : fill_r;
    ic_e   = end_r ? '0 : in_cnt_r;
    oc_e   = end_r ? '0 : out_cnt_r;
    fill_n = (fill_e == srcc_pkg::FILL_W'(srcc_pkg::WIN_DEPTH))
           ? fill_e : fill_e + srcc_pkg::FILL_W'(1);
    ic_n   = ic_e + srcc_pkg::POS_W'(1);
    emitn  = fill_n > {{(srcc_pkg::FILL_W-srcc_pkg::HALF_W){1'b0}}, cfg.half};
    oc1    = oc_e + srcc_pkg::POS_W'(emitn);
    pend   = ic_n - oc1;
    cap    = emitn ? srcc_pkg::JOB_CNT_W'(srcc_pkg::RES_MAX - 1)
                   : srcc_pkg::JOB_CNT_W'(srcc_pkg::RES_MAX);
    if (!in_chan.row_last) begin
      flush = '0;
    end else if (pend > {{(srcc_pkg::POS_W-srcc_pkg::JOB_CNT_W){1'b0}}, cap}) begin
      flush = cap;
    end else begin
      flush = pend[srcc_pkg::JOB_CNT_W-1:0];
    end
  end

  // next state
  always_comb begin
    win_nxt      = win_r;
    fill_nxt     = fill_r;
    in_cnt_nxt   = in_cnt_r;
    out_cnt_nxt  = out_cnt_r;
    end_nxt      = end_r;
    gen_cnt_nxt  = gen_cnt_r;
    gen_norm_nxt = gen_norm_r;
    gen_pos_nxt  = gen_pos_r;
    if (push) begin
      gen_cnt_nxt  = cnt_m1;
      gen_norm_nxt = 1'b0;
      gen_pos_nxt  = gen_pos_r + srcc_pkg::POS_W'(1);
    end
    if (accept) begin
      win_nxt      = {win_r[srcc_pkg::WIN_DEPTH-2:0], in_chan.pixel};
      fill_nxt     = fill_n;
      in_cnt_nxt   = ic_n;
      out_cnt_nxt  = oc1;
      end_nxt      = in_chan.row_last;
      gen_cnt_nxt  = srcc_pkg::JOB_CNT_W'(emitn) + flush;
      gen_norm_nxt = emitn;
      gen_pos_nxt  = oc_e;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r     <= '0;
      in_cnt_r   <= '0;
      out_cnt_r  <= '0;
      end_r      <= 1'b0;
      gen_cnt_r  <= '0;
      gen_norm_r <= 1'b0;
      gen_pos_r  <= '0;
    end else begin
      fill_r     <= fill_nxt;
      in_cnt_r   <= in_cnt_nxt;
      out_cnt_r  <= out_cnt_nxt;
      end_r      <= end_nxt;
      gen_cnt_r  <= gen_cnt_nxt;
      gen_norm_r <= gen_norm_nxt;
      gen_pos_r  <= gen_pos_nxt;
    end
  end

  // window payload, read only below the fill
  always_ff @(posedge clk) begin
    win_r <= win_nxt;
  end

endmodule

`default_nettype wire

>>> rtl/srcc_job_fifo.sv
// ----------------------------------------------------------------------------
// srcc_job_fifo: two-entry job queue
// decouples the input side from the filter pipeline
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srcc_job_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_valid,
  input  srcc_pkg::job_t wr_job,
  output logic           wr_ready,
  output logic           rd_valid,
  output srcc_pkg::job_t rd_job,
  input  logic           rd_ready
);

  srcc_pkg::job_t mem_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           push, pop;

  // flags from registered count only
  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_job   = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

endmodule

`default_nettype wire

>>> rtl/srcc_back.sv
// ----------------------------------------------------------------------------
// srcc_back: filter pipeline of the row convolution
// edge-clamped tap selection with symmetric pre-add, eight multiplier
// lanes, a two-level sum, then rounding and saturation into the output
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srcc_back (
  input  logic           clk,
  input  logic           rst_n,
  input  srcc_pkg::cfg_t cfg,
  input  logic           job_valid,
  input  srcc_pkg::job_t job,
  output logic           job_ready,
  srcc_out_if.source     out_chan
);

  localparam int NT = srcc_pkg::N_TAPS;

  // pipeline advance: everything moves unless the output word is stuck
  logic adv;
  assign adv       = !out_chan.valid || out_chan.ready;
  assign job_ready = adv;

  // stage 1: clamped selection and pre-add
  logic [srcc_pkg::WIN_IDX_W-1:0] top;
  logic [srcc_pkg::WIN_IDX_W-1:0] m_ext;
  logic [srcc_pkg::WIN_IDX_W-1:0] hi_raw [NT];
  logic [srcc_pkg::WIN_IDX_W-1:0] lo_raw [NT];
  logic [srcc_pkg::WIN_IDX_W-1:0] hi_idx [NT];
  logic [srcc_pkg::WIN_IDX_W-1:0] lo_idx [NT];
  logic [srcc_pkg::PIX_W-1:0]     pa [NT];
  logic [srcc_pkg::PIX_W-1:0]     pb [NT];
  logic [srcc_pkg::SUM_W-1:0]     s1_sum_nxt [NT];

  always_comb begin
    top   = srcc_pkg::WIN_IDX_W'(job.fill - srcc_pkg::FILL_W'(1));
    m_ext = srcc_pkg::WIN_IDX_W'(job.m);
    for (int j = 0; j < NT; j++) begin
      hi_raw[j] = m_ext + srcc_pkg::WIN_IDX_W'(j);
      lo_raw[j] = m_ext - srcc_pkg::WIN_IDX_W'(j);
      hi_idx[j] = (hi_raw[j] > top) ? top : hi_raw[j];
      if (m_ext < srcc_pkg::WIN_IDX_W'(j)) begin
        lo_idx[j] = '0;
      end else begin
        lo_idx[j] = (lo_raw[j] > top) ? top : lo_raw[j];
      end
      pa[j] = job.win[hi_idx[j]];
      pb[j] = job.win[lo_idx[j]];
      if (j == 0) begin
        s1_sum_nxt[j] = {1'b0, pa[j]};
      end else begin
        s1_sum_nxt[j] = {1'b0, pa[j]} + {1'b0, pb[j]};
      end
    end
  end

  logic                       s1_v_r;
  logic [srcc_pkg::SUM_W-1:0] s1_sum_r [NT];
  logic [srcc_pkg::POS_W-1:0] s1_pos_r;
  logic                       s1_last_r;

  // stage 2: one multiplier per lane, taps beyond the half-width masked
  logic [srcc_pkg::TAP_W-1:0]  tap_eff [NT];
  logic [srcc_pkg::PROD_W-1:0] s2_prod_nxt [NT];

  always_comb begin
    for (int j = 0; j < NT; j++) begin
      tap_eff[j]     = (srcc_pkg::HALF_W'(j) <= cfg.half) ? cfg.taps[j] : '0;
      s2_prod_nxt[j] = srcc_pkg::PROD_W'(s1_sum_r[j]) * srcc_pkg::PROD_W'(tap_eff[j]);
    end
  end

  logic                        s2_v_r;
  logic [srcc_pkg::PROD_W-1:0] s2_prod_r [NT];
  logic [srcc_pkg::POS_W-1:0]  s2_pos_r;
  logic                        s2_last_r;

  // stage 3: two partial sums of four lanes each
  logic [srcc_pkg::PART_W-1:0] s3_lo_nxt, s3_hi_nxt;

  always_comb begin
    s3_lo_nxt = srcc_pkg::PART_W'(s2_prod_r[0]) + srcc_pkg::PART_W'(s2_prod_r[1])
              + srcc_pkg::PART_W'(s2_prod_r[2]) + srcc_pkg::PART_W'(s2_prod_r[3]);
    s3_hi_nxt = srcc_pkg::PART_W'(s2_prod_r[4]) + srcc_pkg::PART_W'(s2_prod_r[5])
              + srcc_pkg::PART_W'(s2_prod_r[6]) + srcc_pkg::PART_W'(s2_prod_r[7]);
  end

  logic                        s3_v_r;
  logic [srcc_pkg::PART_W-1:0] s3_lo_r, s3_hi_r;
  logic [srcc_pkg::POS_W-1:0]  s3_pos_r;
  logic                        s3_last_r;

  // stage 4: final add, round half up, saturate
  logic [srcc_pkg::ACC_W-1:0] acc;
  logic [srcc_pkg::RND_W-1:0] rnd;
  logic [srcc_pkg::PIX_W-1:0] sat;

  always_comb begin
    acc = srcc_pkg::ACC_W'(s3_lo_r) + srcc_pkg::ACC_W'(s3_hi_r)
        + srcc_pkg::ACC_W'(1 << (srcc_pkg::TAP_W - 1));
    rnd = acc[srcc_pkg::ACC_W-1:srcc_pkg::TAP_W];
    sat = (|rnd[srcc_pkg::RND_W-1:srcc_pkg::PIX_W]) ? '1 : rnd[srcc_pkg::PIX_W-1:0];
  end

  logic                       out_v_r;
  logic [srcc_pkg::PIX_W-1:0] out_pix_r;
  logic [srcc_pkg::POS_W-1:0] out_pos_r;
  logic                       out_last_r;

  assign out_chan.valid         = out_v_r;
  assign out_chan.blurred_pixel = out_pix_r;
  assign out_chan.position      = out_pos_r;
  assign out_chan.last_of_row   = out_last_r;

  // stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r  <= job_valid;
      s2_v_r  <= s1_v_r;
      s3_v_r  <= s2_v_r;
      out_v_r <= s3_v_r;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_sum_r   <= s1_sum_nxt;
      s1_pos_r   <= job.pos;
      s1_last_r  <= job.last;
      s2_prod_r  <= s2_prod_nxt;
      s2_pos_r   <= s1_pos_r;
      s2_last_r  <= s1_last_r;
      s3_lo_r    <= s3_lo_nxt;
      s3_hi_r    <= s3_hi_nxt;
      s3_pos_r   <= s2_pos_r;
      s3_last_r  <= s2_last_r;
      out_pix_r  <= sat;
      out_pos_r  <= s3_pos_r;
      out_last_r <= s3_last_r;
    end
  end

endmodule

`default_nettype wire
